@@ rtl/psmaa_pkg.sv @@
// Package for the per-sensor moving average alarm block.
// Holds field widths, register codes, reset values and the controller types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package psmaa_pkg;

   localparam int WINDOW_LENGTH_DEF = 5;
   localparam int MAX_SENSORS_DEF   = 16;

   localparam int ID_W   = 16;
   localparam int TEMP_W = 16;

   localparam int APB_DW      = 32;
   localparam int APB_AW      = 3;
   localparam int REG_SEL_BIT = 2;

   localparam logic REG_MIN_TEMP = 1'b0;
   localparam logic REG_MAX_TEMP = 1'b1;

   localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd5120;
   localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd6400;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR,
      ST_WRITE,
      ST_SUM,
      ST_ABS,
      ST_MUL,
      ST_FIX,
      ST_ROUND,
      ST_OUT
   } psmaa_state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic clear;
      logic write;
      logic sum;
      logic absval;
      logic mul;
      logic fix;
      logic round;
      logic load_out;
   } psmaa_cmd_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic full;
      logic k_last;
      logic sum_done;
      logic out_free;
   } psmaa_stat_type;

endpackage

`default_nettype wire

@@ rtl/psmaa_req_if.sv @@
// Reading channel: valid/ready handshake carrying a sensor id and a temperature.
// Depends on psmaa_pkg for the field widths.
`default_nettype none

interface psmaa_req_if import psmaa_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [ID_W-1:0]          node_id;
   logic signed [TEMP_W-1:0] temperature;

   modport source (output valid, output node_id, output temperature, input ready);
   modport sink   (input valid, input node_id, input temperature, output ready);

endinterface

`default_nettype wire

@@ rtl/psmaa_rsp_if.sv @@
// Result channel: valid/ready handshake carrying the average and alarm flags.
// Depends on psmaa_pkg for the field widths.
`default_nettype none

interface psmaa_rsp_if import psmaa_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] average;
   logic                     window_filled;
   logic                     below_min;
   logic                     above_max;
   logic                     new_sensor;
   logic                     table_full_drop;

   modport source (
      output valid, output average, output window_filled, output below_min,
      output above_max, output new_sensor, output table_full_drop, input ready
   );
   modport sink (
      input valid, input average, input window_filled, input below_min,
      input above_max, input new_sensor, input table_full_drop, output ready
   );

endinterface

`default_nettype wire

@@ rtl/psmaa_csr.sv @@
// APB-style register file holding the lower and upper temperature limits.
// Depends on psmaa_pkg for widths, register codes and reset values.
`default_nettype none

module psmaa_csr import psmaa_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [APB_AW-1:0]        paddr,
   input  wire logic [APB_DW-1:0]        pwdata,
   output logic      [APB_DW-1:0]        prdata,
   output logic                          pready,
   output logic signed [TEMP_W-1:0]      min_limit,
   output logic signed [TEMP_W-1:0]      max_limit
);

   logic signed [TEMP_W-1:0] min_ff, min_in;
   logic signed [TEMP_W-1:0] max_ff, max_in;
   logic                     wr_en;
   logic                     reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[REG_SEL_BIT];

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MIN_TEMP: min_in = $signed(pwdata[TEMP_W-1:0]);
            REG_MAX_TEMP: max_in = $signed(pwdata[TEMP_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_TEMP_RESET;
         max_ff <= MAX_TEMP_RESET;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MIN_TEMP: prdata = APB_DW'(min_ff);
         REG_MAX_TEMP: prdata = APB_DW'(max_ff);
         default:      prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign min_limit = min_ff;
   assign max_limit = max_ff;

endmodule

`default_nettype wire

@@ rtl/psmaa_ctrl.sv @@
// Controller state machine: sequences lookup, window update, sum, divide and output.
// Depends on psmaa_pkg for the state, command and status types.
`default_nettype none

module psmaa_ctrl import psmaa_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire psmaa_stat_type  stat,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output psmaa_cmd_type        cmd
);

   psmaa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            priority if (stat.hit) begin
               state_in = ST_WRITE;
            end else if (stat.miss && stat.full) begin
               state_in = ST_OUT;
            end else if (stat.miss) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_CLEAR: begin
            if (stat.k_last) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_SUM;
         ST_SUM: begin
            if (stat.sum_done) state_in = ST_ABS;
         end
         ST_ABS:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_ROUND;
         ST_ROUND: state_in = ST_OUT;
         ST_OUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SCAN:  cmd.scan     = 1'b1;
         ST_CLEAR: cmd.clear    = 1'b1;
         ST_WRITE: cmd.write    = 1'b1;
         ST_SUM:   cmd.sum      = 1'b1;
         ST_ABS:   cmd.absval   = 1'b1;
         ST_MUL:   cmd.mul      = 1'b1;
         ST_FIX:   cmd.fix      = 1'b1;
         ST_ROUND: cmd.round    = 1'b1;
         ST_OUT:   cmd.load_out = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/psmaa_dp.sv @@
// Datapath: sensor table and window memories, search counter, accumulator,
// reciprocal divider and the result register. Depends on psmaa_pkg and psmaa_rsp_if.
`default_nettype none

module psmaa_dp import psmaa_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int MAX_SENSORS   = MAX_SENSORS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire psmaa_cmd_type            cmd,
   output psmaa_stat_type                stat,
   input  wire logic [ID_W-1:0]          req_node_id,
   input  wire logic signed [TEMP_W-1:0] req_temperature,
   input  wire logic signed [TEMP_W-1:0] min_limit,
   input  wire logic signed [TEMP_W-1:0] max_limit,
   psmaa_rsp_if.source                   rsp_chan
);

   localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CNT_W     = $clog2(MAX_SENSORS + 1);
   localparam int POS_W     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int WA_W      = IDX_W + POS_W;
   localparam int WIN_DEPTH = MAX_SENSORS * (2 ** POS_W);
   localparam int SUM_W     = TEMP_W + $clog2(WINDOW_LENGTH);
   localparam int DIV_S     = SUM_W;
   localparam int RECIP_W   = DIV_S + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << DIV_S) / WINDOW_LENGTH);
   localparam logic [SUM_W-1:0]   WL_SUM   = SUM_W'(WINDOW_LENGTH);
   localparam logic [POS_W-1:0]   LAST_POS = POS_W'(WINDOW_LENGTH - 1);
   localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_SENSORS);

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] pos;
      logic             filled;
   } entry_type;

   entry_type         ent_mem [MAX_SENSORS];
   entry_type         ent_rd_ff;
   logic [TEMP_W-1:0] win_mem [WIN_DEPTH];
   logic [TEMP_W-1:0] win_rd_ff;

   logic [ID_W-1:0]          id_ff, id_in;
   logic [TEMP_W-1:0]        temp_ff, temp_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     filled_ff, filled_in;
   logic                     new_ff, new_in;
   logic                     drop_ff, drop_in;
   logic [POS_W-1:0]         k_ff, k_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]         abs_ff, abs_in;
   logic                     neg_ff, neg_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [SUM_W-1:0]         q_ff, q_in;
   logic [SUM_W-1:0]         rem_ff, rem_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;

   logic                     out_vld_ff, out_vld_in;
   logic signed [TEMP_W-1:0] out_avg_ff, out_avg_in;
   logic                     out_filled_ff, out_filled_in;
   logic                     out_below_ff, out_below_in;
   logic                     out_above_ff, out_above_in;
   logic                     out_new_ff, out_new_in;
   logic                     out_drop_ff, out_drop_in;

   logic              scan_more;
   logic              scan_hit;
   logic              scan_miss;
   logic              table_full;
   logic              k_last;
   logic [POS_W-1:0]  pos_next;
   logic              filled_next;
   logic [SUM_W-1:0]  q_est;
   logic [SUM_W-1:0]  q_times;
   logic [SUM_W-1:0]  q_corr;
   logic              win_we;
   logic [WA_W-1:0]   win_wa;
   logic [TEMP_W-1:0] win_wd;
   logic              win_re;
   logic [WA_W-1:0]   win_ra;

   assign scan_more   = scan_ff < count_ff;
   assign scan_hit    = cmp_vld_ff && (ent_rd_ff.id == id_ff);
   assign scan_miss   = !cmp_vld_ff && !scan_more;
   assign table_full  = count_ff == MAX_CNT;
   assign k_last      = k_ff == LAST_POS;
   assign pos_next    = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
   assign filled_next = filled_ff || (pos_ff == LAST_POS);
   assign q_est       = prod_ff[DIV_S +: SUM_W];
   assign q_times     = q_est * WL_SUM;
   assign q_corr      = (rem_ff >= WL_SUM) ? q_ff + SUM_W'(1) : q_ff;

   assign stat.hit      = scan_hit;
   assign stat.miss     = scan_miss;
   assign stat.full     = table_full;
   assign stat.k_last   = k_last;
   assign stat.sum_done = issue_done_ff && !rd_vld_ff;
   assign stat.out_free = !out_vld_ff || rsp_chan.ready;

   assign win_we = cmd.clear || cmd.write;
   assign win_wa = {slot_ff, (cmd.write ? pos_ff : k_ff)};
   assign win_wd = cmd.write ? temp_ff : '0;
   assign win_re = cmd.sum && !issue_done_ff;
   assign win_ra = {slot_ff, k_ff};

   always_comb begin
      id_in         = id_ff;
      temp_in       = temp_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      filled_in     = filled_ff;
      new_in        = new_ff;
      drop_in       = drop_ff;
      k_in          = k_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = rd_vld_ff;
      sum_in        = sum_ff;
      abs_in        = abs_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      avg_in        = avg_ff;

      if (cmd.capture) begin
         id_in      = req_node_id;
         temp_in    = req_temperature;
         scan_in    = '0;
         cmp_vld_in = 1'b0;
         new_in     = 1'b0;
         drop_in    = 1'b0;
         k_in       = '0;
      end

      if (cmd.scan) begin
         cmp_vld_in = scan_more;
         if (scan_more) begin
            scan_in    = scan_ff + CNT_W'(1);
            cmp_idx_in = scan_ff[IDX_W-1:0];
         end
         priority if (scan_hit) begin
            slot_in   = cmp_idx_ff;
            pos_in    = ent_rd_ff.pos;
            filled_in = ent_rd_ff.filled;
         end else if (scan_miss && table_full) begin
            drop_in = 1'b1;
         end else if (scan_miss) begin
            slot_in   = count_ff[IDX_W-1:0];
            pos_in    = '0;
            filled_in = 1'b0;
            new_in    = 1'b1;
            count_in  = count_ff + CNT_W'(1);
         end else begin
            slot_in = slot_ff;
         end
      end

      if (cmd.clear) begin
         k_in = k_last ? '0 : k_ff + POS_W'(1);
      end

      if (cmd.write) begin
         pos_in        = pos_next;
         filled_in     = filled_next;
         k_in          = '0;
         issue_done_in = 1'b0;
         rd_vld_in     = 1'b0;
         sum_in        = '0;
      end

      if (cmd.sum) begin
         rd_vld_in = !issue_done_ff;
         if (!issue_done_ff) begin
            k_in          = k_last ? '0 : k_ff + POS_W'(1);
            issue_done_in = k_last;
         end
         if (rd_vld_ff) begin
            sum_in = sum_ff + SUM_W'($signed(win_rd_ff));
         end
      end

      if (cmd.absval) begin
         neg_in = sum_ff[SUM_W-1];
         abs_in = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(abs_ff) * PROD_W'(RECIP);
      end

      if (cmd.fix) begin
         q_in   = q_est;
         rem_in = abs_ff - q_times;
      end

      if (cmd.round) begin
         avg_in = neg_ff ? $signed(-q_corr[TEMP_W-1:0]) : $signed(q_corr[TEMP_W-1:0]);
      end
   end

   always_comb begin
      out_vld_in    = out_vld_ff;
      out_avg_in    = out_avg_ff;
      out_filled_in = out_filled_ff;
      out_below_in  = out_below_ff;
      out_above_in  = out_above_ff;
      out_new_in    = out_new_ff;
      out_drop_in   = out_drop_ff;
      priority if (cmd.load_out) begin
         out_vld_in = 1'b1;
         if (drop_ff) begin
            out_avg_in    = '0;
            out_filled_in = 1'b0;
            out_below_in  = 1'b0;
            out_above_in  = 1'b0;
            out_new_in    = 1'b0;
            out_drop_in   = 1'b1;
         end else begin
            out_avg_in    = avg_ff;
            out_filled_in = filled_ff;
            out_below_in  = filled_ff && (avg_ff < min_limit);
            out_above_in  = filled_ff && (avg_ff > max_limit);
            out_new_in    = new_ff;
            out_drop_in   = 1'b0;
         end
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && scan_more) begin
         ent_rd_ff <= ent_mem[scan_ff[IDX_W-1:0]];
      end
      if (cmd.write) begin
         ent_mem[slot_ff] <= '{id: id_ff, pos: pos_next, filled: filled_next};
      end
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_wa] <= win_wd;
      end
      if (win_re) begin
         win_rd_ff <= win_mem[win_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         scan_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         new_ff        <= 1'b0;
         drop_ff       <= 1'b0;
         k_ff          <= '0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         cmp_vld_ff    <= cmp_vld_in;
         new_ff        <= new_in;
         drop_ff       <= drop_in;
         k_ff          <= k_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      temp_ff       <= temp_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      filled_ff     <= filled_in;
      sum_ff        <= sum_in;
      abs_ff        <= abs_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      avg_ff        <= avg_in;
      out_avg_ff    <= out_avg_in;
      out_filled_ff <= out_filled_in;
      out_below_ff  <= out_below_in;
      out_above_ff  <= out_above_in;
      out_new_ff    <= out_new_in;
      out_drop_ff   <= out_drop_in;
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.average         = out_avg_ff;
   assign rsp_chan.window_filled   = out_filled_ff;
   assign rsp_chan.below_min       = out_below_ff;
   assign rsp_chan.above_max       = out_above_ff;
   assign rsp_chan.new_sensor      = out_new_ff;
   assign rsp_chan.table_full_drop = out_drop_ff;

endmodule

`default_nettype wire

@@ rtl/per_sensor_moving_average_alarm.sv @@
// Top level of the per-sensor moving average alarm block.
// Depends on psmaa_pkg, psmaa_req_if, psmaa_rsp_if, psmaa_csr, psmaa_ctrl and psmaa_dp.
//
// Each beat on req_chan is a reading: a sensor id and a signed Q8.8 temperature.
// The id is searched in the sensor table one entry per cycle; an unknown id takes
// the next free entry and its window is cleared, or is dropped when the table is full.
// Each reading produces exactly one beat on rsp_chan with the truncated window
// average, the filled, alarm, new-entry and drop flags.
// The limits are written through the APB port: offset 0 is the lower limit and
// offset 4 the upper limit; the user must make writes only while the block is idle
// for them to take effect then, as the block itself does not enforce this.
// One reading is processed at a time: the table search, for a new id the clearing of
// its window, the write into the window, the sum over it and the absolute value,
// multiply, fix and round steps before the result register loads; a dropped reading
// goes from the search straight to the output. The search and the window clear and
// sum set how long a reading takes. The block is ready for the next reading once the
// result register has loaded, even if the receiver has not taken it; when the receiver
// stalls, the next result holds in the output state until that register frees up.
// Reset empties the table, restores the default limits and drops any pending beat.
`default_nettype none

module per_sensor_moving_average_alarm import psmaa_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int MAX_SENSORS   = MAX_SENSORS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   psmaa_req_if.sink              req_chan,
   psmaa_rsp_if.source            rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [APB_AW-1:0] paddr,
   input  wire logic [APB_DW-1:0] pwdata,
   output logic      [APB_DW-1:0] prdata,
   output logic                   pready
);

   psmaa_cmd_type            cmd;
   psmaa_stat_type           stat;
   logic signed [TEMP_W-1:0] min_limit;
   logic signed [TEMP_W-1:0] max_limit;
   logic                     ctrl_ready;

   psmaa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .min_limit (min_limit),
      .max_limit (max_limit)
   );

   psmaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .cmd       (cmd)
   );

   psmaa_dp #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .MAX_SENSORS   (MAX_SENSORS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_node_id     (req_chan.node_id),
      .req_temperature (req_chan.temperature),
      .min_limit       (min_limit),
      .max_limit       (max_limit),
      .rsp_chan        (rsp_chan)
   );

   assign req_chan.ready = ctrl_ready;

endmodule

`default_nettype wire
